[rtl/vtpy_pkg.sv]
// Shared constants, types and the arctangent table for the vector to pitch/yaw block.
`timescale 1ns / 1ps
`default_nettype none
package vtpy_pkg;

  localparam int CORDIC_STAGES   = 20;
  localparam int COMPONENT_WIDTH = 24;
  localparam int ANGLE_FRAC_BITS = 16;

  // Internal angles carry this many fraction bits of a degree.
  localparam int INT_FRAC    = 24;
  localparam int GUARD_SHIFT = 58 - COMPONENT_WIDTH;
  // Datapath width holds the scaled components with CORDIC and planar growth.
  localparam int DW      = 62;
  localparam int AW      = 35;
  localparam int OUT_W   = 25;
  localparam int STAGE_W = 5;
  localparam int RND_SH  = INT_FRAC - ANGLE_FRAC_BITS;

  localparam logic [31:0] INV_GAIN = 32'd2608131496;

  localparam logic signed [AW-1:0] HALF_TURN = AW'(64'(180) << INT_FRAC);
  localparam logic [OUT_W-1:0] OUT_LIMIT = OUT_W'(64'(360) << ANGLE_FRAC_BITS);
  localparam logic [OUT_W-1:0] PITCH_DOWN = OUT_W'(64'(270) << ANGLE_FRAC_BITS);
  localparam logic [OUT_W-1:0] PITCH_UP   = OUT_W'(64'(90) << ANGLE_FRAC_BITS);

  // atan(2^-i) in degrees, scaled by 2^24 and rounded.
  localparam int ATAN_TAB [32] = '{
    754974720, 445687602, 235489088, 119537938,
    60000934, 30029717, 15018523, 7509720,
    3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335,
    14668, 7334, 3667, 1833,
    917, 458, 229, 115,
    57, 29, 14, 7,
    4, 2, 1, 0
  };

  function automatic logic signed [AW-1:0] atan_step(input logic [STAGE_W-1:0] i);
    return AW'(ATAN_TAB[i]);
  endfunction

  // Data that rides along the chain untouched by the CORDIC cells.
  typedef struct packed {
    logic                 zero;
    logic                 zpos;
    logic signed [DW-1:0] nz;
    logic signed [AW-1:0] yaw;
  } side_t;

  typedef struct packed {
    logic                 valid;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [AW-1:0] ang;
    side_t                side;
  } stage_t;

endpackage
`default_nettype wire

[rtl/vtpy_if.sv]
// Valid/ready channel interfaces for the input vector and the angle result.
`timescale 1ns / 1ps
`default_nettype none
interface vtpy_in_if;
  logic valid;
  logic ready;
  logic signed [vtpy_pkg::COMPONENT_WIDTH-1:0] dir_x;
  logic signed [vtpy_pkg::COMPONENT_WIDTH-1:0] dir_y;
  logic signed [vtpy_pkg::COMPONENT_WIDTH-1:0] dir_z;
  modport source (output valid, dir_x, dir_y, dir_z, input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface vtpy_out_if;
  logic valid;
  logic ready;
  logic [vtpy_pkg::OUT_W-1:0] pitch_deg;
  logic [vtpy_pkg::OUT_W-1:0] yaw_deg;
  modport source (output valid, pitch_deg, yaw_deg, input ready);
  modport sink (input valid, pitch_deg, yaw_deg, output ready);
endinterface
`default_nettype wire

[rtl/vtpy_cell.sv]
// One vectoring CORDIC micro-rotation cell of the chain.
`timescale 1ns / 1ps
`default_nettype none
module vtpy_cell (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire logic [vtpy_pkg::STAGE_W-1:0]   stage,
  input  wire vtpy_pkg::stage_t               d,
  output vtpy_pkg::stage_t                    q
);

  logic signed [vtpy_pkg::DW-1:0] xs;
  logic signed [vtpy_pkg::DW-1:0] ys;
  logic signed [vtpy_pkg::DW-1:0] dx;
  logic signed [vtpy_pkg::DW-1:0] dy;
  vtpy_pkg::stage_t               q_next;

  // Rotate toward the x axis; a residual of zero leaves everything as is.
  always_comb begin
    xs = d.x;
    ys = d.y;
    dx = ys >>> stage;
    dy = xs >>> stage;
    q_next = d;
    if (ys > 0) begin
      q_next.x   = xs + dx;
      q_next.y   = ys - dy;
      q_next.ang = d.ang + vtpy_pkg::atan_step(stage);
    end else if (ys < 0) begin
      q_next.x   = xs - dx;
      q_next.y   = ys + dy;
      q_next.ang = d.ang - vtpy_pkg::atan_step(stage);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule
`default_nettype wire

[rtl/vtpy_gain.sv]
// Two-stage inverse CORDIC gain scaling that turns the yaw result into pitch input.
`timescale 1ns / 1ps
`default_nettype none
module vtpy_gain (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en_a,
  input  wire logic             en_b,
  input  wire vtpy_pkg::stage_t d,
  output vtpy_pkg::stage_t      mid,
  output vtpy_pkg::stage_t      q
);

  logic [vtpy_pkg::DW-1:0] ux;
  logic [vtpy_pkg::DW-33:0] hi;
  logic [31:0] lo;
  logic [vtpy_pkg::DW+31-32:0] prod_hi;
  logic [63:0] prod_lo;
  vtpy_pkg::stage_t mid_next;
  vtpy_pkg::stage_t q_next;

  // First stage: the two partial products of length times inverse gain.
  always_comb begin
    ux = d.x[vtpy_pkg::DW-1] ? '0 : d.x;
    hi = ux[vtpy_pkg::DW-1:32];
    lo = ux[31:0];
    prod_hi = hi * vtpy_pkg::INV_GAIN;
    prod_lo = 64'(lo) * 64'(vtpy_pkg::INV_GAIN);
    mid_next = d;
    mid_next.x = vtpy_pkg::DW'(prod_hi);
    mid_next.y = vtpy_pkg::DW'(prod_lo[63:32]);
  end

  // Second stage: sum the products and set up the pitch vector.
  always_comb begin
    q_next = mid;
    q_next.x = mid.x + mid.y;
    q_next.y = mid.side.nz;
    q_next.ang = '0;
    q_next.side.yaw = mid.ang;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid <= 1'b0;
      q.valid   <= 1'b0;
    end else begin
      if (en_a) begin
        mid <= mid_next;
      end
      if (en_b) begin
        q <= q_next;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/vector_to_pitch_yaw_top.sv]
// Top level: direction vector to pitch and yaw through two chains of CORDIC cells.
// Stages from an accepted input beat to its result beat: input register,
//   20 yaw cells, 2 gain stages, 20 pitch cells, output register.
// Throughput: one beat per cycle unless the output stalls; every stage holds one item and stalls only when full
//   and the stage after it cannot move, so bubbles are squeezed out.
// Reset: synchronous rst clears all stage valid flags; no results are pending after it.
`timescale 1ns / 1ps
`default_nettype none
module vector_to_pitch_yaw_top (
  input  wire logic clk,
  input  wire logic rst,
  vtpy_in_if.sink   in_ch,
  vtpy_out_if.source out_ch
);

  localparam int S  = vtpy_pkg::CORDIC_STAGES;
  localparam int N  = 2 * S + 3;
  localparam int AW = vtpy_pkg::AW;
  localparam int DW = vtpy_pkg::DW;
  localparam int CW = vtpy_pkg::COMPONENT_WIDTH;
  localparam logic signed [AW:0] FULL_S = (AW+1)'(64'(360) << vtpy_pkg::INT_FRAC);
  localparam logic [AW:0] ROUND = (AW+1)'((64'(1) << vtpy_pkg::RND_SH) >> 1);
  localparam logic [AW:0] LIMIT = (AW+1)'(64'(360) << vtpy_pkg::ANGLE_FRAC_BITS);

  vtpy_pkg::stage_t pipe [N];
  logic [N:0]       en;

  logic                 out_valid;
  logic [vtpy_pkg::OUT_W-1:0] pitch_deg;
  logic [vtpy_pkg::OUT_W-1:0] yaw_deg;

  logic signed [DW-1:0] xs;
  logic signed [DW-1:0] ys;
  logic signed [DW-1:0] zs;
  vtpy_pkg::stage_t     in_next;

  function automatic logic [vtpy_pkg::OUT_W-1:0] to_out(input logic signed [AW-1:0] a);
    logic signed [AW:0] t;
    logic [AW:0] r;
    t = {a[AW-1], a};
    if (t < 0) t = t + FULL_S;
    if (t < 0) t = '0;
    if (t >= FULL_S) t = t - FULL_S;
    r = ($unsigned(t) + ROUND) >> vtpy_pkg::RND_SH;
    if (r >= LIMIT) r = LIMIT - 1'b1;
    return r[vtpy_pkg::OUT_W-1:0];
  endfunction

  // A stage may load when it is empty or its contents move on this cycle.
  assign en[N] = !out_valid || out_ch.ready;
  for (genvar k = 0; k < N; k++) begin : g_en
    assign en[k] = !pipe[k].valid || en[k+1];
  end
  assign in_ch.ready = en[0];

  // Input register: scale, fold the left half plane and note the special cases.
  always_comb begin
    xs = {{(DW-CW){in_ch.dir_x[CW-1]}}, in_ch.dir_x} <<< vtpy_pkg::GUARD_SHIFT;
    ys = {{(DW-CW){in_ch.dir_y[CW-1]}}, in_ch.dir_y} <<< vtpy_pkg::GUARD_SHIFT;
    zs = {{(DW-CW){in_ch.dir_z[CW-1]}}, in_ch.dir_z} <<< vtpy_pkg::GUARD_SHIFT;
    in_next.valid = in_ch.valid;
    in_next.side.zero = (in_ch.dir_x == '0) && (in_ch.dir_y == '0);
    in_next.side.zpos = !in_ch.dir_z[CW-1] && (in_ch.dir_z != '0);
    in_next.side.nz = -zs;
    in_next.side.yaw = '0;
    if (xs < 0) begin
      in_next.x   = -xs;
      in_next.y   = -ys;
      in_next.ang = vtpy_pkg::HALF_TURN;
    end else begin
      in_next.x   = xs;
      in_next.y   = ys;
      in_next.ang = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].valid <= 1'b0;
    end else if (en[0]) begin
      pipe[0] <= in_next;
    end
  end

  // Yaw chain.
  for (genvar i = 0; i < S; i++) begin : g_yaw
    vtpy_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en[i+1]),
      .stage (vtpy_pkg::STAGE_W'(i)),
      .d     (pipe[i]),
      .q     (pipe[i+1])
    );
  end

  vtpy_gain u_gain (
    .clk  (clk),
    .rst  (rst),
    .en_a (en[S+1]),
    .en_b (en[S+2]),
    .d    (pipe[S]),
    .mid  (pipe[S+1]),
    .q    (pipe[S+2])
  );

  // Pitch chain.
  for (genvar i = 0; i < S; i++) begin : g_pitch
    vtpy_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en[S+3+i]),
      .stage (vtpy_pkg::STAGE_W'(i)),
      .d     (pipe[S+2+i]),
      .q     (pipe[S+3+i])
    );
  end

  // Output register with wrap, rounding and the degenerate vertical case.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en[N]) begin
      out_valid <= pipe[N-1].valid;
      if (pipe[N-1].side.zero) begin
        pitch_deg <= pipe[N-1].side.zpos ? vtpy_pkg::PITCH_DOWN : vtpy_pkg::PITCH_UP;
        yaw_deg   <= '0;
      end else begin
        pitch_deg <= to_out(pipe[N-1].ang);
        yaw_deg   <= to_out(pipe[N-1].side.yaw);
      end
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.pitch_deg = pitch_deg;
  assign out_ch.yaw_deg   = yaw_deg;

endmodule
`default_nettype wire

[rtl/vtpy_chk.sv]
// Port-level checker for the vector to pitch/yaw block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module vtpy_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [vtpy_pkg::OUT_W-1:0] pitch_deg,
  input wire logic [vtpy_pkg::OUT_W-1:0] yaw_deg
);

  // A stalled result beat stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pitch_deg) && $stable(yaw_deg))
    else $error("result beat changed while stalled");

  // Angles always lie below a full turn.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch_deg < vtpy_pkg::OUT_LIMIT) && (yaw_deg < vtpy_pkg::OUT_LIMIT))
    else $error("angle at or beyond 360 degrees");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind vector_to_pitch_yaw_top vtpy_chk u_vtpy_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pitch_deg (out_ch.pitch_deg),
  .yaw_deg   (out_ch.yaw_deg)
);
`default_nettype wire
